[rtl/quadratic_real_roots_unit_macros.svh]
// Assertion macros used by the checker file of the quadratic root unit.
`ifndef QUADRATIC_REAL_ROOTS_UNIT_MACROS_SVH
`define QUADRATIC_REAL_ROOTS_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define QRR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define QRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/qrr_pkg.sv]
// Shared types, constants and helpers of the quadratic root unit.
package qrr_pkg;

  localparam int CoefWidth       = 16;
  localparam int RootWidth       = 48;
  localparam int FracBitsDefault = 16;
  localparam int DiscWidth       = 2 * CoefWidth + 1;
  localparam int QueueDepth      = 4;

  typedef enum logic [1:0] {
    StNoRoot   = 2'd0,
    StDouble   = 2'd1,
    StTwoRoots = 2'd2,
    StLinear   = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [CoefWidth-1:0] coef_quad;
    logic signed [CoefWidth-1:0] coef_lin;
    logic signed [CoefWidth-1:0] coef_const;
  } item_t;

  typedef struct packed {
    status_e                     status;
    logic signed [RootWidth-1:0] first_root;
    logic signed [RootWidth-1:0] second_root;
  } result_t;

  // Classified item handed from the front end to the solver
  typedef struct packed {
    status_e                     status;
    logic signed [CoefWidth-1:0] coef_quad;
    logic signed [CoefWidth-1:0] coef_lin;
    logic [DiscWidth-1:0]        disc;
  } mid_t;

  // Magnitude of a two's complement coefficient
  function automatic logic [CoefWidth-1:0] coef_mag(logic signed [CoefWidth-1:0] v);
    logic [CoefWidth-1:0] u;
    u = v;
    return v[CoefWidth-1] ? (~u + 1'b1) : u;
  endfunction

endpackage

[rtl/quadratic_real_roots_unit.sv]
// Top level of the quadratic real root solver.
//
// Input channel: drive item_i with a, b, c and raise push; the set transfers
// on a clock edge where push is high and full is low.
// Result channel: while empty is low, result_o holds the oldest result; it
// transfers on a clock edge where pop is high and empty is low.
// Each set yields one result: status, then (-b-S)/(2a) and (-b+S)/(2a) as
// signed fixed point with FRAC_BITS fraction bits, zero where absent.
// The solver has one square root stage per root bit and one divider stage
// per quotient bit.
// Throughput: one set per cycle while the receiver keeps pop high; every
// stage is pipelined.
// A stalled receiver freezes the solver pipeline; the front end keeps taking
// sets until its stages and the four-entry queue fill, then raises full.
// Reset (rst_ni low, asynchronous) empties every stage and the queue.
module quadratic_real_roots_unit #(
  parameter int FRAC_BITS = qrr_pkg::FracBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  qrr_pkg::item_t   item_i,
  output logic             empty,
  input  logic             pop,
  output qrr_pkg::result_t result_o
);

  logic          q_push, q_full, q_pop, q_empty;
  qrr_pkg::mid_t q_in, q_out;

  qrr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .item_i   (item_i),
    .q_push_o (q_push),
    .q_full_i (q_full),
    .q_item_o (q_in)
  );

  qrr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .full_o  (q_full),
    .item_i  (q_in),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_out)
  );

  qrr_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_pop_o   (q_pop),
    .q_empty_i (q_empty),
    .q_item_i  (q_out),
    .pop_i     (pop),
    .empty_o   (empty),
    .result_o  (result_o)
  );

endmodule

[rtl/qrr_front.sv]
// Front end: takes coefficient sets, forms the discriminant and classifies it.
module qrr_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  qrr_pkg::item_t item_i,
  output logic           q_push_o,
  input  logic           q_full_i,
  output qrr_pkg::mid_t  q_item_o
);

  localparam int CW    = qrr_pkg::CoefWidth;
  localparam int ProdW = 2 * CW;
  localparam int DW    = qrr_pkg::DiscWidth;

  qrr_pkg::item_t          f1_q;
  logic                    f1_v_q, f2_v_q;
  logic [ProdW-1:0]        bsq_q, ac_q;
  logic signed [CW-1:0]    a_q, b_q;
  logic                    a_zero_q, c_zero_q, ac_neg_q;
  logic                    adv1, adv2;
  logic [CW-1:0]           a_mag, b_mag, c_mag;
  logic [DW:0]             bsq_x, four_ac, disc_sum, disc_diff;
  logic [DW-1:0]           disc;

  // Stage enables: stage 2 drains into the queue
  assign adv2     = !f2_v_q || !q_full_i;
  assign adv1     = !f1_v_q || adv2;
  assign full_o   = !adv1;
  assign q_push_o = f2_v_q && !q_full_i;

  assign a_mag = qrr_pkg::coef_mag(f1_q.coef_quad);
  assign b_mag = qrr_pkg::coef_mag(f1_q.coef_lin);
  assign c_mag = qrr_pkg::coef_mag(f1_q.coef_const);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else begin
      if (adv1) f1_v_q <= push_i;
      if (adv2) f2_v_q <= f1_v_q;
    end
  end

  // Input register and product stage
  always_ff @(posedge clk_i) begin
    if (adv1 && push_i) f1_q <= item_i;
    if (adv2 && f1_v_q) begin
      bsq_q    <= ProdW'(b_mag) * ProdW'(b_mag);
      ac_q     <= ProdW'(a_mag) * ProdW'(c_mag);
      a_q      <= f1_q.coef_quad;
      b_q      <= f1_q.coef_lin;
      a_zero_q <= (f1_q.coef_quad == '0);
      c_zero_q <= (f1_q.coef_const == '0);
      ac_neg_q <= f1_q.coef_quad[CW-1] ^ f1_q.coef_const[CW-1];
    end
  end

  // Discriminant and classification
  assign bsq_x     = (DW+1)'(bsq_q);
  assign four_ac   = {ac_q, 2'b00};
  assign disc_sum  = bsq_x + four_ac;
  assign disc_diff = bsq_x - four_ac;

  always_comb begin
    q_item_o.coef_quad = a_q;
    q_item_o.coef_lin  = b_q;
    disc               = '0;
    q_item_o.status    = qrr_pkg::StNoRoot;
    if (a_zero_q) begin
      q_item_o.status = qrr_pkg::StLinear;
    end else if (ac_neg_q || c_zero_q) begin
      disc            = disc_sum[DW-1:0];
      q_item_o.status = (disc == '0) ? qrr_pkg::StDouble : qrr_pkg::StTwoRoots;
    end else if (bsq_x >= four_ac) begin
      disc            = disc_diff[DW-1:0];
      q_item_o.status = (disc == '0) ? qrr_pkg::StDouble : qrr_pkg::StTwoRoots;
    end
    q_item_o.disc = disc;
  end

endmodule

[rtl/qrr_queue.sv]
// Short queue between the front end and the solver.
module qrr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  qrr_pkg::mid_t item_i,
  input  logic          pop_i,
  output logic          empty_o,
  output qrr_pkg::mid_t item_o
);

  localparam int Depth = qrr_pkg::QueueDepth;
  localparam int PtrW  = $clog2(Depth);

  qrr_pkg::mid_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == (PtrW+1)'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

[rtl/qrr_back.sv]
// Solver: pipelined square root, two pipelined dividers and the result register.
module qrr_back #(
  parameter int FRAC_BITS = qrr_pkg::FracBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  output logic             q_pop_o,
  input  logic             q_empty_i,
  input  qrr_pkg::mid_t    q_item_i,
  input  logic             pop_i,
  output logic             empty_o,
  output qrr_pkg::result_t result_o
);

  localparam int CW   = qrr_pkg::CoefWidth;
  localparam int SW   = CW + FRAC_BITS + 1;   // square root bits
  localparam int RadW = 2 * SW;               // radicand bits
  localparam int NbW  = CW + FRAC_BITS + 1;   // scaled -b
  localparam int QW   = CW + FRAC_BITS + 2;   // numerator and quotient bits
  localparam int RW   = qrr_pkg::RootWidth;

  typedef struct packed {
    qrr_pkg::status_e     status;
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic [RadW-1:0]      rad;
    logic [SW+1:0]        rem;
    logic [SW-1:0]        root;
  } sq_stage_t;

  typedef struct packed {
    qrr_pkg::status_e status;
    logic             neg1;
    logic             neg2;
    logic [CW:0]      dmag;
    logic [QW-1:0]    num1;
    logic [QW-1:0]    num2;
    logic [QW-1:0]    q1;
    logic [QW-1:0]    q2;
    logic [CW:0]      rem1;
    logic [CW:0]      rem2;
  } dv_stage_t;

  sq_stage_t        sq_q [SW+1];
  dv_stage_t        dv_q [QW+1];
  logic [SW:0]      sq_v_q;
  logic [QW:0]      dv_v_q;
  logic             out_v_q;
  qrr_pkg::result_t out_q;
  logic             en;

  // Whole pipeline moves when the result register is free or being drained
  assign en       = !out_v_q || pop_i;
  assign q_pop_o  = en && !q_empty_i;
  assign empty_o  = !out_v_q;
  assign result_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q  <= '0;
      dv_v_q  <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      sq_v_q  <= {sq_v_q[SW-1:0], !q_empty_i};
      dv_v_q  <= {dv_v_q[QW-1:0], sq_v_q[SW]};
      out_v_q <= dv_v_q[QW];
    end
  end

  // Square root entry: radicand is the discriminant scaled by 2^(2*FRAC_BITS)
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0].status <= q_item_i.status;
      sq_q[0].a      <= q_item_i.coef_quad;
      sq_q[0].b      <= q_item_i.coef_lin;
      sq_q[0].rad    <= RadW'(q_item_i.disc) << (2 * FRAC_BITS);
      sq_q[0].rem    <= '0;
      sq_q[0].root   <= '0;
    end
  end

  // One root bit per stage, two radicand bits consumed
  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    logic [SW+1:0] cur, trial, diff;
    logic          ge;

    always_comb begin
      cur   = {sq_q[k].rem[SW-1:0], sq_q[k].rad[RadW-1 -: 2]};
      trial = {sq_q[k].root, 2'b01};
      ge    = (cur >= trial);
      diff  = cur - trial;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[k+1].status <= sq_q[k].status;
        sq_q[k+1].a      <= sq_q[k].a;
        sq_q[k+1].b      <= sq_q[k].b;
        sq_q[k+1].rad    <= sq_q[k].rad << 2;
        sq_q[k+1].rem    <= ge ? diff : cur;
        sq_q[k+1].root   <= {sq_q[k].root[SW-2:0], ge};
      end
    end
  end

  // Numerators -b*2^F -/+ S and the divisor magnitude
  logic signed [NbW-1:0] b_ext, nb;
  logic signed [QW-1:0]  s_ext, n1, n2;
  logic [CW-1:0]         a_mag;

  always_comb begin
    b_ext = NbW'(sq_q[SW].b);
    nb    = -(b_ext <<< FRAC_BITS);
    s_ext = $signed({1'b0, sq_q[SW].root});
    n1    = QW'(nb) - s_ext;
    n2    = QW'(nb) + s_ext;
    a_mag = qrr_pkg::coef_mag(sq_q[SW].a);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0].status <= sq_q[SW].status;
      dv_q[0].neg1   <= n1[QW-1] ^ sq_q[SW].a[CW-1];
      dv_q[0].neg2   <= n2[QW-1] ^ sq_q[SW].a[CW-1];
      dv_q[0].dmag   <= {a_mag, 1'b0};
      dv_q[0].num1   <= n1[QW-1] ? QW'(-n1) : QW'(n1);
      dv_q[0].num2   <= n2[QW-1] ? QW'(-n2) : QW'(n2);
      dv_q[0].q1     <= '0;
      dv_q[0].q2     <= '0;
      dv_q[0].rem1   <= '0;
      dv_q[0].rem2   <= '0;
    end
  end

  // One quotient bit per stage for both roots
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [CW+1:0] cur1, cur2, dext, diff1, diff2;
    logic          ge1, ge2;

    always_comb begin
      dext  = {1'b0, dv_q[k].dmag};
      cur1  = {dv_q[k].rem1, dv_q[k].num1[QW-1]};
      cur2  = {dv_q[k].rem2, dv_q[k].num2[QW-1]};
      ge1   = (cur1 >= dext);
      ge2   = (cur2 >= dext);
      diff1 = cur1 - dext;
      diff2 = cur2 - dext;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[k+1].status <= dv_q[k].status;
        dv_q[k+1].neg1   <= dv_q[k].neg1;
        dv_q[k+1].neg2   <= dv_q[k].neg2;
        dv_q[k+1].dmag   <= dv_q[k].dmag;
        dv_q[k+1].num1   <= dv_q[k].num1 << 1;
        dv_q[k+1].num2   <= dv_q[k].num2 << 1;
        dv_q[k+1].q1     <= {dv_q[k].q1[QW-2:0], ge1};
        dv_q[k+1].q2     <= {dv_q[k].q2[QW-2:0], ge2};
        dv_q[k+1].rem1   <= ge1 ? diff1[CW:0] : cur1[CW:0];
        dv_q[k+1].rem2   <= ge2 ? diff2[CW:0] : cur2[CW:0];
      end
    end
  end

  // Sign fix-up and selection by status
  logic signed [QW-1:0] r1, r2;
  qrr_pkg::result_t     res_d;

  always_comb begin
    r1 = dv_q[QW].neg1 ? -$signed(dv_q[QW].q1) : $signed(dv_q[QW].q1);
    r2 = dv_q[QW].neg2 ? -$signed(dv_q[QW].q2) : $signed(dv_q[QW].q2);
    res_d.status      = dv_q[QW].status;
    res_d.first_root  = '0;
    res_d.second_root = '0;
    case (dv_q[QW].status)
      qrr_pkg::StDouble: begin
        res_d.first_root = RW'(r1);
      end
      qrr_pkg::StTwoRoots: begin
        res_d.first_root  = RW'(r1);
        res_d.second_root = RW'(r2);
      end
      default: begin
        res_d.first_root  = '0;
        res_d.second_root = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= res_d;
  end

endmodule

[rtl/qrr_checker.sv]
// Port-level checks of the quadratic root unit and their binding.
`include "quadratic_real_roots_unit_macros.svh"

module qrr_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             push,
  input logic             full,
  input qrr_pkg::item_t   item_i,
  input logic             empty,
  input logic             pop,
  input qrr_pkg::result_t result_o
);

  logic absent_st, double_st, roots_zero, stall;

  // Status views of the waiting result
  assign absent_st  = !empty && (result_o.status == qrr_pkg::StNoRoot ||
                                 result_o.status == qrr_pkg::StLinear);
  assign double_st  = !empty && (result_o.status == qrr_pkg::StDouble);
  assign roots_zero = (result_o.first_root == '0) && (result_o.second_root == '0);
  assign stall      = !empty && !pop;

  // No-root and linear cases carry zero roots
  `QRR_ASSERT_SAME(a_absent_zero, absent_st, roots_zero, "absent roots not zero")

  // Double root leaves the second slot zero
  `QRR_ASSERT_SAME(a_double_second_zero, double_st, result_o.second_root == '0, "double root has second root")

  // A waiting result stays put until taken
  `QRR_ASSERT_NEXT(a_result_hold, stall, !empty && $stable(result_o), "result changed while stalled")

endmodule

bind quadratic_real_roots_unit qrr_checker u_qrr_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .item_i   (item_i),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

[dv/quadratic_real_roots_unit_test.sv]
// Self-checking testbench for the quadratic real root solver.
`timescale 1ns / 1ps

module quadratic_real_roots_unit_test;

  localparam int FracBits = qrr_pkg::FracBitsDefault;
  localparam int NumRandom = 1330;
  localparam int Latency = 2 * 16 + 2 * FracBits + 8;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             push = 1'b0;
  logic             pop = 1'b0;
  qrr_pkg::item_t   item_i = '0;
  logic             full;
  logic             empty;
  qrr_pkg::result_t result_o;

  qrr_pkg::result_t expected_roots[$];
  int               n_errors = 0;
  bit               no_idle = 1'b0;

  typedef struct {
    qrr_pkg::item_t   coefs;
    bit               has_known;
    qrr_pkg::result_t known;
  } vector_t;

  quadratic_real_roots_unit #(.FRAC_BITS(FracBits)) dut (
    .clk_i, .rst_ni, .push, .full, .item_i, .empty, .pop, .result_o
  );

  always #10 clk_i = ~clk_i;

  // Floor square root of a value below 2^98
  function automatic logic [63:0] floor_sqrt(logic [127:0] x);
    logic [63:0]  r;
    logic [63:0]  cand;
    logic [127:0] sq;
    r = '0;
    for (int k = 50; k >= 0; k--) begin
      cand = r | (64'd1 << k);
      sq = 128'(cand) * 128'(cand);
      if (sq <= x) r = cand;
    end
    return r;
  endfunction

  // Expected status and fixed point roots for one coefficient set
  function automatic qrr_pkg::result_t solve_roots(qrr_pkg::item_t it);
    qrr_pkg::result_t   r;
    logic signed [63:0] qa, qb, qc, nb, den, s;
    logic signed [63:0] disc;
    qa = it.coef_quad;
    qb = it.coef_lin;
    qc = it.coef_const;
    r = '0;
    r.status = qrr_pkg::StLinear;
    if (qa == 0) return r;
    disc = qb * qb - 4 * qa * qc;
    r.status = qrr_pkg::StNoRoot;
    if (disc < 0) return r;
    nb = -(qb <<< FracBits);
    den = 2 * qa;
    if (disc == 0) begin
      r.status = qrr_pkg::StDouble;
      r.first_root = 48'(nb / den);
      return r;
    end
    s = $signed(floor_sqrt(128'(disc) << (2 * FracBits)));
    r.status = qrr_pkg::StTwoRoots;
    r.first_root = 48'((nb - s) / den);
    r.second_root = 48'((nb + s) / den);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s mismatch: got %0d expected %0d", $realtime, what, got, want);
    n_errors++;
  endtask

  // Send one set and wait for its transfer
  task automatic send_item(qrr_pkg::item_t it, bit has_known, qrr_pkg::result_t known);
    qrr_pkg::result_t want;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    push <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
    want = has_known ? known : solve_roots(it);
    expected_roots.push_back(want);
  endtask

  // Result side: random stall bursts, compare each transfer
  initial begin
    qrr_pkg::result_t want;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (expected_roots.size() == 0) begin
          report_mismatch("unexpected result status", result_o.status, 0);
        end else begin
          want = expected_roots.pop_front();
          if (result_o.status !== want.status)
            report_mismatch("status", result_o.status, want.status);
          if (result_o.first_root !== want.first_root)
            report_mismatch("first_root", result_o.first_root, want.first_root);
          if (result_o.second_root !== want.second_root)
            report_mismatch("second_root", result_o.second_root, want.second_root);
        end
      end
      if (!no_idle && pop && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        pop <= 1'b1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic qrr_pkg::item_t rand_item();
    qrr_pkg::item_t it;
    int             mode;
    mode = $urandom_range(0, 9);
    it = qrr_pkg::item_t'(48'({$urandom(), $urandom()}));
    case (mode)
      0: it.coef_quad = '0;
      // small values hit double roots and sign changes often
      1, 2: begin
        it.coef_quad = 16'($signed($urandom_range(0, 8)) - 4);
        it.coef_lin = 16'($signed($urandom_range(0, 16)) - 8);
        it.coef_const = 16'($signed($urandom_range(0, 8)) - 4);
      end
      // perfect square: a*(x-r)^2 with a = 1
      3: begin
        it.coef_quad = 16'd1;
        it.coef_lin = 16'($signed($urandom_range(0, 200)) - 100);
        it.coef_const = 16'((it.coef_lin / 2) * (it.coef_lin / 2));
        it.coef_lin = 16'(2 * (it.coef_lin / 2));
      end
      default: ;
    endcase
    return it;
  endfunction

  // Directed table then random sets
  initial begin
    vector_t          vec[$];
    qrr_pkg::result_t zero_res;
    zero_res = '0;
    vec.push_back('{'{16'sd0, 16'sd5, 16'sd3}, 1, '{qrr_pkg::StLinear, 48'd0, 48'd0}});
    vec.push_back('{'{16'sd0, 16'sh8000, 16'sd32767}, 1,
                    '{qrr_pkg::StLinear, 48'd0, 48'd0}});
    vec.push_back('{'{16'sd1, 16'sd0, 16'sd1}, 1, '{qrr_pkg::StNoRoot, 48'd0, 48'd0}});
    vec.push_back('{'{16'sd32767, 16'sd0, 16'sd32767}, 1,
                    '{qrr_pkg::StNoRoot, 48'd0, 48'd0}});
    vec.push_back('{'{16'sd1, 16'sd0, 16'sd0}, 1, '{qrr_pkg::StDouble, 48'd0, 48'd0}});
    vec.push_back('{'{16'sd1, -16'sd2, 16'sd1}, 1,
                    '{qrr_pkg::StDouble, 48'sd65536, 48'd0}});
    vec.push_back('{'{-16'sd1, 16'sd2, -16'sd1}, 1,
                    '{qrr_pkg::StDouble, 48'sd65536, 48'd0}});
    vec.push_back('{'{16'sd1, 16'sd0, -16'sd1}, 1,
                    '{qrr_pkg::StTwoRoots, -48'sd65536, 48'sd65536}});
    vec.push_back('{'{-16'sd1, 16'sd0, 16'sd1}, 1,
                    '{qrr_pkg::StTwoRoots, 48'sd65536, -48'sd65536}});
    vec.push_back('{'{16'sd1, 16'sd0, -16'sd2}, 0, zero_res});
    vec.push_back('{'{16'sd1, 16'sh8000, 16'sh8000}, 0, zero_res});
    vec.push_back('{'{16'sh8000, 16'sh8000, 16'sd32767}, 0, zero_res});
    vec.push_back('{'{16'sd32767, 16'sd32767, 16'sh8000}, 0, zero_res});
    vec.push_back('{'{16'sh8000, 16'sd32767, 16'sh8000}, 0, zero_res});
    vec.push_back('{'{16'sd1, 16'sd32767, 16'sd0}, 0, zero_res});
    vec.push_back('{'{-16'sd1, 16'sh8000, 16'sh8000}, 0, zero_res});
    vec.push_back('{'{16'sd3, 16'sd7, 16'sd2}, 0, zero_res});
    vec.push_back('{'{16'sh8000, 16'sd0, 16'sd0}, 1,
                    '{qrr_pkg::StDouble, 48'd0, 48'd0}});
    vec.push_back('{'{16'sd2, 16'sd3, -16'sd5}, 0, zero_res});
    vec.push_back('{'{16'hffff, 16'hffff, 16'hffff}, 0, zero_res});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (vec[i]) send_item(vec[i].coefs, vec[i].has_known, vec[i].known);
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom - 200) no_idle = 1'b1;
      send_item(rand_item(), 1'b0, zero_res);
    end
    push <= 1'b0;
    while (expected_roots.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("** quadratic_real_roots_unit: PASSED **");
    end else begin
      $display("** quadratic_real_roots_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("** quadratic_real_roots_unit: FAILED **");
    $finish;
  end

endmodule
